[design/e2ec_pkg.sv]
// Shared types, constants and the byte-wide CRC-64/XZ update for the E2E message check.
`default_nettype none
package e2ec_pkg;

	localparam int unsigned HDR_BYTES = 20;
	localparam int unsigned POS_W     = 5;

	localparam logic [POS_W-1:0] POS_CRC_END  = POS_W'(8);
	localparam logic [POS_W-1:0] POS_LEN_END  = POS_W'(12);
	localparam logic [POS_W-1:0] POS_CNT_END  = POS_W'(16);
	localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(HDR_BYTES);
	localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HDR_BYTES - 1);

	localparam logic [63:0] CRC64_POLY     = 64'hC96C5795D7870F42;
	localparam logic [63:0] CRC64_ALL_ONES = 64'hFFFFFFFFFFFFFFFF;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} msg_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] received_crc;
		logic [63:0] computed_crc;
		logic [31:0] msg_length;
		logic [31:0] msg_counter;
		logic [31:0] data_ident;
	} res_item_t;

	// handshake control from the core to the two register stages
	typedef struct packed {
		logic consume;
		logic emit;
	} core_ctl_t;

	// reflected CRC-64, one byte, LSB first
	function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
		logic [63:0] c;
		c = crc ^ {56'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC64_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[design/e2e_crc64_message_check_unit.sv]
// Top level of the E2E CRC-64/XZ message check.
`default_nettype none
// Takes one message byte per transaction and accepts a byte on every clock while
// the result side keeps up. A byte sits in the input register while the core folds
// it into the header capture and the byte-wide CRC-64/XZ update. The result is
// formed combinationally from the final byte and written to the output register
// when the core consumes that byte, which waits while a held result is not taken.
// The byte-wide CRC update between the input and result registers sets the one
// byte per cycle rate. Only a final byte waits on a held result; other bytes pass.
// Each final byte gives exactly one result with status ok, too short or crc mismatch.
module e2e_crc64_message_check_unit
	import e2ec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_stall,
	input  wire msg_item_t msg_item,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item
);

	core_ctl_t ctl;
	logic      item_valid_s1;
	msg_item_t item_s1;
	logic      out_free;
	res_item_t result;

	e2ec_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg_item     (msg_item),
		.ctl          (ctl),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1)
	);

	e2ec_msg_core u_msg_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid_s1(item_valid_s1),
		.item_s1      (item_s1),
		.out_free     (out_free),
		.ctl          (ctl),
		.result       (result)
	);

	e2ec_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.result   (result),
		.out_free (out_free),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

endmodule
`default_nettype wire

[design/e2ec_in_stage.sv]
// Input register stage for message bytes.
`default_nettype none
module e2ec_in_stage
	import e2ec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_stall,
	input  wire msg_item_t msg_item,
	input  wire core_ctl_t ctl,
	output logic           item_valid_s1,
	output msg_item_t      item_s1
);

	logic accept;

	assign msg_stall = item_valid_s1 && !ctl.consume;
	assign accept    = msg_valid && !msg_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (ctl.consume) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= msg_item;
		end
	end

endmodule
`default_nettype wire

[design/e2ec_msg_core.sv]
// Header capture, running CRC, results; one byte per cycle unless output is held.
`default_nettype none
module e2ec_msg_core
	import e2ec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid_s1,
	input  wire msg_item_t item_s1,
	input  wire logic      out_free,
	output core_ctl_t      ctl,
	output res_item_t      result
);

	logic [POS_W-1:0] byte_position_q;
	logic [63:0]      running_crc_q;
	logic [63:0]      header_crc_q;
	logic [31:0]      header_length_q;
	logic [31:0]      header_counter_q;
	logic [31:0]      header_data_id_q;

	logic [63:0] crc_nxt;
	logic [63:0] hcrc_nxt;
	logic [31:0] hlen_nxt;
	logic [31:0] hcnt_nxt;
	logic [31:0] hid_nxt;
	logic [63:0] crc_final;
	logic        last;
	logic        consume;

	assign last = item_s1.last_byte;

	// a byte that ends nothing can go even while the output is held
	assign consume     = item_valid_s1 && (!last || out_free);
	assign ctl.consume = consume;
	assign ctl.emit    = consume && last;

	always_comb begin
		hcrc_nxt = header_crc_q;
		hlen_nxt = header_length_q;
		hcnt_nxt = header_counter_q;
		hid_nxt  = header_data_id_q;
		if (byte_position_q < POS_CRC_END) begin
			hcrc_nxt = {header_crc_q[55:0], item_s1.data_byte};
		end else if (byte_position_q < POS_LEN_END) begin
			hlen_nxt = {header_length_q[23:0], item_s1.data_byte};
		end else if (byte_position_q < POS_CNT_END) begin
			hcnt_nxt = {header_counter_q[23:0], item_s1.data_byte};
		end else if (byte_position_q < POS_HDR_END) begin
			hid_nxt = {header_data_id_q[23:0], item_s1.data_byte};
		end
		crc_nxt = (byte_position_q >= POS_CRC_END) ?
			crc64_byte(running_crc_q, item_s1.data_byte) : running_crc_q;
	end

	assign crc_final = crc_nxt ^ CRC64_ALL_ONES;

	always_comb begin
		if (byte_position_q < POS_HDR_LAST) begin
			result.status       = STATUS_SHORT;
			result.received_crc = '0;
			result.computed_crc = '0;
			result.msg_length   = '0;
			result.msg_counter  = '0;
			result.data_ident   = '0;
		end else begin
			result.status       = (crc_final == hcrc_nxt) ? STATUS_OK : STATUS_MISMATCH;
			result.received_crc = hcrc_nxt;
			result.computed_crc = crc_final;
			result.msg_length   = hlen_nxt;
			result.msg_counter  = hcnt_nxt;
			result.data_ident   = hid_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			running_crc_q    <= CRC64_ALL_ONES;
			header_crc_q     <= '0;
			header_length_q  <= '0;
			header_counter_q <= '0;
			header_data_id_q <= '0;
		end else if (consume) begin
			if (last) begin
				byte_position_q  <= '0;
				running_crc_q    <= CRC64_ALL_ONES;
				header_crc_q     <= '0;
				header_length_q  <= '0;
				header_counter_q <= '0;
				header_data_id_q <= '0;
			end else begin
				if (byte_position_q < POS_HDR_END) begin
					byte_position_q <= byte_position_q + POS_W'(1);
				end
				running_crc_q    <= crc_nxt;
				header_crc_q     <= hcrc_nxt;
				header_length_q  <= hlen_nxt;
				header_counter_q <= hcnt_nxt;
				header_data_id_q <= hid_nxt;
			end
		end
	end

endmodule
`default_nettype wire

[design/e2ec_out_stage.sv]
// Result register stage holding one check result until taken.
`default_nettype none
module e2ec_out_stage
	import e2ec_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_ctl_t ctl,
	input  wire res_item_t result,
	output logic           out_free,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_item
);

	logic      res_valid_q;
	res_item_t res_item_q;

	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_item_q <= result;
		end
	end

endmodule
`default_nettype wire

[design/e2ec_check.sv]
// Port-level checks for the E2E message check, bound to the top level.
`default_nettype none
module e2ec_check
	import e2ec_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      msg_valid,
	input wire logic      msg_stall,
	input wire msg_item_t msg_item,
	input wire logic      res_valid,
	input wire logic      res_stall,
	input wire res_item_t res_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result transaction dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_item))
		else $error("result payload changed while stalled");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == STATUS_OK |->
			res_item.received_crc == res_item.computed_crc)
		else $error("ok status with differing crc values");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.status == STATUS_SHORT |->
			res_item.received_crc == '0 && res_item.computed_crc == '0 &&
			res_item.msg_length == '0 && res_item.msg_counter == '0 &&
			res_item.data_ident == '0)
		else $error("short message result carries non-zero fields");

endmodule

bind e2e_crc64_message_check_unit e2ec_check u_e2ec_check (.*);
`default_nettype wire

[test/testbench.sv]
// Testbench for the E2E CRC-64/XZ message check unit: framed byte stimulus with a scoreboard.
`timescale 1ns / 1ps
module testbench;
	import e2ec_pkg::*;

	typedef enum int {MSG_GOOD, MSG_BAD_CRC, MSG_NOISE} msg_kind_t;

	// Predicts the result of each message and checks the results as they arrive
	class msg_check_scoreboard;
		logic [POS_W-1:0] pos;
		logic [63:0]      crc_reg;
		logic [63:0]      hdr_crc;
		logic [31:0]      hdr_len;
		logic [31:0]      hdr_cnt;
		logic [31:0]      hdr_id;
		res_item_t        pending[$];
		int unsigned      errors;
		int unsigned      bytes_seen;
		int unsigned      n_ok;
		int unsigned      n_short;
		int unsigned      n_mismatch;

		function new();
			errors     = 0;
			bytes_seen = 0;
			n_ok       = 0;
			n_short    = 0;
			n_mismatch = 0;
			clear();
		endfunction

		function void clear();
			pos     = '0;
			crc_reg = CRC64_ALL_ONES;
			hdr_crc = '0;
			hdr_len = '0;
			hdr_cnt = '0;
			hdr_id  = '0;
		endfunction

		// reflected update, one bit at a time
		static function logic [63:0] crc_step(input logic [63:0] c, input logic [7:0] b);
			logic [63:0] r;
			r = c;
			for (int k = 0; k < 8; k++) begin
				if (r[0] ^ b[k])
					r = (r >> 1) ^ CRC64_POLY;
				else
					r = r >> 1;
			end
			return r;
		endfunction

		function void note_byte(input msg_item_t it);
			logic [POS_W-1:0] p;
			res_item_t        r;
			p = pos;
			bytes_seen++;
			if (p < POS_CRC_END)
				hdr_crc = {hdr_crc[55:0], it.data_byte};
			else if (p < POS_LEN_END)
				hdr_len = {hdr_len[23:0], it.data_byte};
			else if (p < POS_CNT_END)
				hdr_cnt = {hdr_cnt[23:0], it.data_byte};
			else if (p < POS_HDR_END)
				hdr_id = {hdr_id[23:0], it.data_byte};
			if (p >= POS_CRC_END)
				crc_reg = crc_step(crc_reg, it.data_byte);
			if (p < POS_HDR_END)
				pos = p + 1'b1;
			if (!it.last_byte)
				return;
			r = '0;
			if (p < POS_HDR_LAST) begin
				r.status = STATUS_SHORT;
			end else begin
				r.computed_crc = crc_reg ^ CRC64_ALL_ONES;
				r.status       = (r.computed_crc == hdr_crc) ? STATUS_OK : STATUS_MISMATCH;
				r.received_crc = hdr_crc;
				r.msg_length   = hdr_len;
				r.msg_counter  = hdr_cnt;
				r.data_ident   = hdr_id;
			end
			pending.push_back(r);
			clear();
		endfunction

		function void report(input string field, input logic [63:0] want, input logic [63:0] got);
			$display("%0t ns: %s mismatch: expected %h, got %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(input res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				$display("%0t ns: unexpected result transaction %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			case (want.status)
				STATUS_OK:    n_ok++;
				STATUS_SHORT: n_short++;
				default:      n_mismatch++;
			endcase
			if (got.status !== want.status)
				report("status", 64'(want.status), 64'(got.status));
			if (got.received_crc !== want.received_crc)
				report("received_crc", want.received_crc, got.received_crc);
			if (got.computed_crc !== want.computed_crc)
				report("computed_crc", want.computed_crc, got.computed_crc);
			if (got.msg_length !== want.msg_length)
				report("msg_length", 64'(want.msg_length), 64'(got.msg_length));
			if (got.msg_counter !== want.msg_counter)
				report("msg_counter", 64'(want.msg_counter), 64'(got.msg_counter));
			if (got.data_ident !== want.data_ident)
				report("data_ident", 64'(want.data_ident), 64'(got.data_ident));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_item_t msg_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;

	msg_check_scoreboard sb;
	int unsigned         burst_left;
	int unsigned         stall_cycle;
	int unsigned         stall_mode;

	e2e_crc64_message_check_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg_valid(msg_valid),
		.msg_stall(msg_stall),
		.msg_item (msg_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// both channels observed at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg_valid && !msg_stall)
				sb.note_byte(msg_item);
			if (res_valid && !res_stall)
				sb.check_result(res_item);
		end
	end

	// receiver back-pressure: mode drawn at random whenever the low byte of stall_cycle is zero
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_cycle[7:0] == 8'd0)
				stall_mode = $urandom_range(0, 3);
			stall_cycle++;
			case (stall_mode)
				0:       res_stall <= 1'b0;
				1:       res_stall <= ($urandom_range(0, 3) == 0);
				2:       res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= (stall_cycle[4:0] < 5'd12);
			endcase
		end
	end

	task automatic send_byte(input msg_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 12);
			gap = $urandom_range(1, 5);
			@(negedge clk);
			msg_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		msg_valid <= 1'b1;
		msg_item  <= it;
		do @(posedge clk); while (msg_stall);
	endtask

	task automatic send_message(input int unsigned len, input msg_kind_t kind,
	                            input bit fill_en, input logic [7:0] fill_val);
		logic [7:0]  msg_bytes[];
		logic [63:0] crc;
		msg_item_t   it;
		msg_bytes = new[len];
		foreach (msg_bytes[i])
			msg_bytes[i] = fill_en ? fill_val : 8'($urandom);
		if (kind != MSG_NOISE && len >= HDR_BYTES) begin
			// length word sometimes matches the payload, otherwise left random or at the fill value
			if (!fill_en && $urandom_range(0, 1))
				{msg_bytes[8], msg_bytes[9], msg_bytes[10], msg_bytes[11]} = 32'(len - HDR_BYTES);
			crc = CRC64_ALL_ONES;
			for (int i = 8; i < len; i++)
				crc = msg_check_scoreboard::crc_step(crc, msg_bytes[i]);
			crc ^= CRC64_ALL_ONES;
			if (kind == MSG_BAD_CRC)
				crc ^= 64'd1 << $urandom_range(0, 63);
			for (int i = 0; i < 8; i++)
				msg_bytes[i] = crc[63 - 8 * i -: 8];
		end
		for (int i = 0; i < len; i++) begin
			it.data_byte = msg_bytes[i];
			it.last_byte = (i == len - 1);
			send_byte(it);
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned len;
		sb          = new();
		burst_left  = 0;
		stall_cycle = 0;
		stall_mode  = 0;
		arst_n      = 1'b0;
		msg_valid   = 1'b0;
		msg_item    = '0;
		res_stall   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// shortest message, then a minimal full header with all-ones length, counter and ident fields
		send_message(1, MSG_NOISE, 1'b1, 8'h00);
		send_message(HDR_BYTES, MSG_GOOD, 1'b1, 8'hFF);

		while (sb.bytes_seen < 1300) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				// mostly just past the header, sometimes well past counter saturation
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 64)
				                                  : $urandom_range(HDR_BYTES, 32);
				send_message(len, MSG_GOOD, 1'b0, 8'h00);
			end else if (pick < 8) begin
				send_message($urandom_range(HDR_BYTES, 40), MSG_BAD_CRC, 1'b0, 8'h00);
			end else begin
				send_message($urandom_range(1, 30), MSG_NOISE, 1'b0, 8'h00);
			end
		end
		@(negedge clk);
		msg_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes; results: %0d ok, %0d too short, %0d crc mismatch.",
		         sb.bytes_seen, sb.n_ok, sb.n_short, sb.n_mismatch);
		$display("Receiver stalls varied between none, light, heavy and periodic.");
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out with %0d results outstanding.", sb.pending.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
